### hdl/ips_patch_stream_parser_unit_assert.svh
// Assertion helpers for the RTL, used by ips_obuf. Both sample on clk.
`ifndef IPS_PATCH_STREAM_PARSER_UNIT_ASSERT_SVH
`define IPS_PATCH_STREAM_PARSER_UNIT_ASSERT_SVH

// Checked only outside reset.
`define IPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define IPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/ips_pkg.sv
package ips_pkg;

  // Input word: one patch byte plus end-of-buffer flag.
  typedef struct packed {
    logic [7:0] patch_byte;
    logic       last;
  } in_word_t;

  typedef enum logic [2:0] {
    KIND_WRITE  = 3'd0,
    KIND_FILL   = 3'd1,
    KIND_DONE   = 3'd2,
    KIND_BADHDR = 3'd3,
    KIND_TRUNC  = 3'd4,
    KIND_BOUNDS = 3'd5
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [23:0] address;
    logic [7:0]  value;
    logic [15:0] run_length;
    logic [24:0] patched_size;
  } out_word_t;

  // Parser result handed to the output buffer.
  typedef struct packed {
    logic      push;
    out_word_t word;
  } res_t;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_ROM_LENGTH = 1'b0;   // register index (paddr[2])
  localparam logic [24:0] ROM_MAX = 25'h100_0000;
  localparam logic [23:0] EOF_MARK = 24'h45_4F_46;  // "EOF"

  // "PATCH" header bytes
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = 8'h50;
      3'd1: b = 8'h41;
      3'd2: b = 8'h54;
      3'd3: b = 8'h43;
      3'd4: b = 8'h48;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/ips_cfg.sv
module ips_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ips_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output logic [24:0]                 rom_limit
);

  logic [24:0] rom_len_r;
  logic [24:0] rom_len_nxt;
  logic        sel_rom;

  assign sel_rom = (cfg_paddr[2] == ips_pkg::REG_ROM_LENGTH);

  always_comb begin
    rom_len_nxt = rom_len_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && sel_rom) begin
      rom_len_nxt = cfg_pwdata[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_len_r <= ips_pkg::ROM_MAX;
    end else begin
      rom_len_r <= rom_len_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = sel_rom ? {7'd0, rom_len_r} : 32'd0;

  // anything past 16 MiB clamps
  assign rom_limit = (rom_len_r > ips_pkg::ROM_MAX) ? ips_pkg::ROM_MAX : rom_len_r;

endmodule

### hdl/ips_parse.sv
module ips_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  ips_pkg::in_word_t in_word,
  input  logic [24:0]       rom_limit,
  output ips_pkg::res_t     res
);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_OFFSET  = 4'd1,
    PH_SIZE    = 4'd2,
    PH_PAYLOAD = 4'd3,
    PH_RCOUNT  = 4'd4,
    PH_RVALUE  = 4'd5
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [23:0] rec_off_r, rec_off_nxt;
  logic [15:0] rec_size_r, rec_size_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [24:0] wr_addr_r, wr_addr_nxt;
  logic [24:0] largest_r, largest_nxt;
  logic        fin_r, fin_nxt;

  logic [7:0]  b;
  logic [15:0] end_len;
  logic [24:0] end_addr;
  ips_pkg::out_word_t w;
  logic        push;

  assign b = in_word.patch_byte;

  // one shared adder for the record end: size in SIZE phase, run count otherwise
  assign end_len  = (phase_r == PH_SIZE) ? {rec_size_r[7:0], b} : remain_r;
  assign end_addr = {1'b0, rec_off_r} + {9'd0, end_len};

  always_comb begin
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    rec_off_nxt  = rec_off_r;
    rec_size_nxt = rec_size_r;
    remain_nxt   = remain_r;
    wr_addr_nxt  = wr_addr_r;
    largest_nxt  = largest_r;
    fin_nxt      = fin_r;
    push         = 1'b0;
    w            = '0;
    w.kind       = ips_pkg::KIND_WRITE;

    if (!fin_r) begin
      case (phase_r)
        PH_HEADER: begin
          if (b != ips_pkg::hdr_byte(cnt_r)) begin
            w.kind  = ips_pkg::KIND_BADHDR;
            push    = 1'b1;
            fin_nxt = 1'b1;
          end else if (cnt_r == 3'd4) begin
            phase_nxt = PH_OFFSET;
            cnt_nxt   = 3'd0;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_OFFSET: begin
          rec_off_nxt = {rec_off_r[15:0], b};
          if (cnt_r == 3'd2) begin
            cnt_nxt = 3'd0;
            if (rec_off_nxt == ips_pkg::EOF_MARK) begin
              w.kind         = ips_pkg::KIND_DONE;
              w.patched_size = largest_r;
              push           = 1'b1;
              fin_nxt        = 1'b1;
            end else begin
              rec_size_nxt = 16'd0;
              phase_nxt    = PH_SIZE;
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_SIZE: begin
          rec_size_nxt = {rec_size_r[7:0], b};
          if (cnt_r == 3'd1) begin
            cnt_nxt = 3'd0;
            if (rec_size_nxt == 16'd0) begin
              remain_nxt = 16'd0;
              phase_nxt  = PH_RCOUNT;
            end else begin
              if (end_addr > largest_r) begin
                largest_nxt = end_addr;
              end
              if (end_addr > rom_limit) begin
                w.kind  = ips_pkg::KIND_BOUNDS;
                push    = 1'b1;
                fin_nxt = 1'b1;
              end else begin
                remain_nxt  = rec_size_nxt;
                wr_addr_nxt = {1'b0, rec_off_r};
                phase_nxt   = PH_PAYLOAD;
              end
            end
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_PAYLOAD: begin
          w.kind      = ips_pkg::KIND_WRITE;
          w.address   = wr_addr_r[23:0];
          w.value     = b;
          push        = 1'b1;
          wr_addr_nxt = wr_addr_r + 25'd1;
          remain_nxt  = remain_r - 16'd1;
          if (remain_nxt == 16'd0) begin
            rec_off_nxt = 24'd0;
            phase_nxt   = PH_OFFSET;
          end
        end
        PH_RCOUNT: begin
          remain_nxt = {remain_r[7:0], b};
          if (cnt_r == 3'd1) begin
            cnt_nxt   = 3'd0;
            phase_nxt = PH_RVALUE;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
        PH_RVALUE: begin
          push = 1'b1;
          if (end_addr > largest_r) begin
            largest_nxt = end_addr;
          end
          if (end_addr > rom_limit) begin
            w.kind  = ips_pkg::KIND_BOUNDS;
            fin_nxt = 1'b1;
          end else begin
            w.kind       = ips_pkg::KIND_FILL;
            w.address    = rec_off_r;
            w.value      = b;
            w.run_length = remain_r;
            rec_off_nxt  = 24'd0;
            phase_nxt    = PH_OFFSET;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end

    // end of buffer: unfinished patch reports truncation, then start over
    if (in_word.last) begin
      if (!fin_nxt) begin
        w      = '0;
        w.kind = ips_pkg::KIND_TRUNC;
        push   = 1'b1;
      end
      phase_nxt    = PH_HEADER;
      cnt_nxt      = 3'd0;
      rec_off_nxt  = 24'd0;
      rec_size_nxt = 16'd0;
      remain_nxt   = 16'd0;
      wr_addr_nxt  = 25'd0;
      largest_nxt  = 25'd0;
      fin_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      cnt_r      <= 3'd0;
      rec_off_r  <= 24'd0;
      rec_size_r <= 16'd0;
      remain_r   <= 16'd0;
      wr_addr_r  <= 25'd0;
      largest_r  <= 25'd0;
      fin_r      <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      rec_off_r  <= rec_off_nxt;
      rec_size_r <= rec_size_nxt;
      remain_r   <= remain_nxt;
      wr_addr_r  <= wr_addr_nxt;
      largest_r  <= largest_nxt;
      fin_r      <= fin_nxt;
    end
  end

  assign res.push = accept && push;
  assign res.word = w;

endmodule

### hdl/ips_obuf.sv
`include "ips_patch_stream_parser_unit_assert.svh"

module ips_obuf (
  input  logic               clk,
  input  logic               rst_n,
  input  ips_pkg::res_t      res,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output ips_pkg::out_word_t out_data
);

  logic               out_v_r, out_v_nxt;
  logic               skid_v_r, skid_v_nxt;
  ips_pkg::out_word_t out_w_r, out_w_nxt;
  ips_pkg::out_word_t skid_w_r, skid_w_nxt;
  logic               pop;

  assign pop = out_v_r && out_ready;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_w_nxt  = out_w_r;
    skid_w_nxt = skid_w_r;
    if (skid_v_r) begin
      if (pop) begin
        out_w_nxt  = skid_w_r;
        skid_v_nxt = 1'b0;
      end
    end else if (res.push) begin
      if (!out_v_r || pop) begin
        out_w_nxt = res.word;
        out_v_nxt = 1'b1;
      end else begin
        skid_w_nxt = res.word;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_w_r  <= out_w_nxt;
    skid_w_r <= skid_w_nxt;
  end

  assign room      = !skid_v_r;
  assign out_valid = out_v_r;
  assign out_data  = out_w_r;

  `IPS_ASSERT(a_skid_behind_out, !skid_v_r || out_v_r, "skid word without output word")
  `IPS_ASSERT(a_skid_holds, skid_v_r && !out_ready |=> skid_v_r, "skid word lost on stall")
  `IPS_ASSERT(a_stall_to_skid, res.push && out_v_r && !out_ready |=> skid_v_r, "result dropped")

endmodule

### hdl/ips_patch_stream_parser_unit.sv
// IPS patch stream parser.
// Input channel (in_valid/in_ready/in_data): one patch byte per word, with
// in_data.last set on the final byte of the buffer. The "PATCH" header is
// checked, then records are parsed; payload bytes leave as write words, RLE
// records as one fill word, an "EOF" offset as a done word carrying the
// largest record end. Bad header, truncation and ROM-bound errors each give
// one error word, after which bytes are dropped until the last flag.
// Result channel (out_valid/out_ready/out_data): at most one word per byte.
// Config port (cfg_*, APB style, pready tied high): rom_length at address 0,
// reset 16777216; write it only while the parser is idle.
// Output: results are registered, in the output register or the skid word.
// Throughput: one byte per cycle while in_ready is high; the parser state
// is updated once per byte; its path is one 25-bit add and two compares.
// Stall: an output register plus one skid word; in_ready drops only while
// the skid word is occupied, so no result is ever lost.
// Reset (rst_n low, synchronous): parser returns to the header phase, the
// output buffer empties and rom_length returns to its default.
module ips_patch_stream_parser_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  ips_pkg::in_word_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ips_pkg::out_word_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [ips_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic          accept;
  logic [24:0]   rom_limit;
  ips_pkg::res_t res;
  logic          room;

  assign in_ready = room;
  assign accept   = in_valid && room;

  ips_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .rom_limit   (rom_limit)
  );

  // byte decode and record state; result word computed in the same cycle
  ips_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_word   (in_data),
    .rom_limit (rom_limit),
    .res       (res)
  );

  // result register plus skid word
  ips_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// Testbench for the IPS patch stream parser.
module tb;

  localparam logic [39:0] PATCH_TEXT = "PATCH";
  // Bytes the parser acts on (not dropped) per idling phase.
  localparam int unsigned LIVE_PER_PHASE = 160;
  // Receiver hold-off used to back the block up into its input.
  localparam int unsigned BACKLOG_HOLD = 80;
  localparam int unsigned BACKLOG_LEN = 48;

  typedef enum logic [2:0] {
    PS_HEADER,
    PS_OFFSET,
    PS_SIZE,
    PS_PAYLOAD,
    PS_RUN_COUNT,
    PS_RUN_VALUE
  } parse_state_t;

  // One row of the directed table. typed=1 means the expected word (or no
  // word) is written in the row; otherwise the parser model decides.
  typedef struct {
    logic [7:0]         patch_byte;
    logic               last;
    bit                 typed;
    bit                 has_word;
    ips_pkg::out_word_t word;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  ips_pkg::in_word_t           in_data;
  logic                        out_valid;
  logic                        out_ready;
  ips_pkg::out_word_t          out_data;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [ips_pkg::PADDR_W-1:0] cfg_paddr;
  logic [31:0]                 cfg_pwdata;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;

  ips_patch_stream_parser_unit dut (.*);

  // 2 ns clock: 1 ns high, 1 ns low.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Idling knobs, changed per phase by the main sequence.
  int unsigned source_gap_pct = 20;
  int unsigned sink_stall_pct = 20;
  int unsigned hold_off_cycles = 0;

  int unsigned mismatch_count = 0;
  int unsigned word_count = 0;
  int unsigned live_bytes = 0;

  // Words the parser owes us, oldest first.
  ips_pkg::out_word_t predicted_words[$];
  stim_row_t directed_rows[$];
  logic [7:0] patch_bytes[$];

  // ---------------------------------------------------------------------
  // Parser model: own copy of the decode state and of rom_length.
  // ---------------------------------------------------------------------
  parse_state_t ps_state;
  logic [2:0]   ps_field_cnt;
  logic [23:0]  ps_offset;
  logic [15:0]  ps_size;
  logic [15:0]  ps_remaining;
  logic [24:0]  ps_wr_addr;
  logic [24:0]  ps_max_end;
  logic         ps_finished;
  logic [24:0]  rom_length_cfg;

  function automatic logic [7:0] header_char(input int idx);
    return PATCH_TEXT[8*(4-idx) +: 8];
  endfunction

  // rom_length values above the max ROM size behave as the max.
  function automatic logic [24:0] rom_bound();
    return (rom_length_cfg > ips_pkg::ROM_MAX) ? ips_pkg::ROM_MAX : rom_length_cfg;
  endfunction

  function automatic void restart_patch();
    ps_state     = PS_HEADER;
    ps_field_cnt = '0;
    ps_offset    = '0;
    ps_size      = '0;
    ps_remaining = '0;
    ps_wr_addr   = '0;
    ps_max_end   = '0;
    ps_finished  = 1'b0;
  endfunction

  // Advance the model by one accepted byte; returns 1 when a word is due.
  function automatic bit decode_patch_byte(input logic [7:0] b, input logic lst,
                                           output ips_pkg::out_word_t w);
    logic [24:0] rec_end;
    bit          hit;
    hit = 1'b0;
    w = '0;
    if (!ps_finished) begin
      live_bytes++;
      case (ps_state)
        PS_HEADER: begin
          if (b != header_char(int'(ps_field_cnt))) begin
            // mismatch reported on the first differing byte
            w.kind = ips_pkg::KIND_BADHDR;
            hit = 1'b1;
            ps_finished = 1'b1;
          end else if (ps_field_cnt == 3'd4) begin
            ps_state = PS_OFFSET;
            ps_field_cnt = '0;
          end else begin
            ps_field_cnt++;
          end
        end
        PS_OFFSET: begin
          ps_offset = {ps_offset[15:0], b};
          if (ps_field_cnt == 3'd2) begin
            ps_field_cnt = '0;
            if (ps_offset == ips_pkg::EOF_MARK) begin
              w.kind = ips_pkg::KIND_DONE;
              w.patched_size = ps_max_end;
              hit = 1'b1;
              ps_finished = 1'b1;
            end else begin
              ps_size = '0;
              ps_state = PS_SIZE;
            end
          end else begin
            ps_field_cnt++;
          end
        end
        PS_SIZE: begin
          ps_size = {ps_size[7:0], b};
          if (ps_field_cnt == 3'd1) begin
            ps_field_cnt = '0;
            if (ps_size == '0) begin
              ps_remaining = '0;
              ps_state = PS_RUN_COUNT;
            end else begin
              rec_end = {1'b0, ps_offset} + 25'(ps_size);
              if (rec_end > ps_max_end) ps_max_end = rec_end;
              // ending exactly at the ROM end is legal
              if (rec_end > rom_bound()) begin
                w.kind = ips_pkg::KIND_BOUNDS;
                hit = 1'b1;
                ps_finished = 1'b1;
              end else begin
                ps_remaining = ps_size;
                ps_wr_addr = {1'b0, ps_offset};
                ps_state = PS_PAYLOAD;
              end
            end
          end else begin
            ps_field_cnt++;
          end
        end
        PS_PAYLOAD: begin
          w.kind = ips_pkg::KIND_WRITE;
          w.address = ps_wr_addr[23:0];
          w.value = b;
          hit = 1'b1;
          ps_wr_addr++;
          ps_remaining--;
          if (ps_remaining == '0) begin
            ps_offset = '0;
            ps_state = PS_OFFSET;
          end
        end
        PS_RUN_COUNT: begin
          ps_remaining = {ps_remaining[7:0], b};
          if (ps_field_cnt == 3'd1) begin
            ps_field_cnt = '0;
            ps_state = PS_RUN_VALUE;
          end else begin
            ps_field_cnt++;
          end
        end
        default: begin
          rec_end = {1'b0, ps_offset} + 25'(ps_remaining);
          if (rec_end > ps_max_end) ps_max_end = rec_end;
          if (rec_end > rom_bound()) begin
            w.kind = ips_pkg::KIND_BOUNDS;
            ps_finished = 1'b1;
          end else begin
            // a zero run count still gives a fill word
            w.kind = ips_pkg::KIND_FILL;
            w.address = ps_offset;
            w.value = b;
            w.run_length = ps_remaining;
            ps_offset = '0;
            ps_state = PS_OFFSET;
          end
          hit = 1'b1;
        end
      endcase
    end
    // Buffer ends without done or error: truncated replaces any other word.
    if (lst) begin
      if (!ps_finished) begin
        w = '0;
        w.kind = ips_pkg::KIND_TRUNC;
        hit = 1'b1;
      end
      restart_patch();
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Outputs are sampled on the rising edge; inputs move on the falling one.
  always @(posedge clk) begin : check_words
    ips_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_words.size() == 0) begin
        flag_mismatch($sformatf("unexpected word kind %0d addr %h",
                                out_data.kind, out_data.address));
      end else begin
        want = predicted_words.pop_front();
        if (out_data.kind !== want.kind)
          flag_mismatch($sformatf("word %0d kind %0d, want %0d",
                                  word_count, out_data.kind, want.kind));
        if (out_data.address !== want.address)
          flag_mismatch($sformatf("word %0d address %h, want %h",
                                  word_count, out_data.address, want.address));
        if (out_data.value !== want.value)
          flag_mismatch($sformatf("word %0d value %h, want %h",
                                  word_count, out_data.value, want.value));
        if (out_data.run_length !== want.run_length)
          flag_mismatch($sformatf("word %0d run_length %h, want %h",
                                  word_count, out_data.run_length, want.run_length));
        if (out_data.patched_size !== want.patched_size)
          flag_mismatch($sformatf("word %0d patched_size %h, want %h",
                                  word_count, out_data.patched_size, want.patched_size));
      end
      word_count++;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked for, counted
  // here so the sender keeps pushing bytes meanwhile.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles != 0) begin
        out_ready = 1'b0;
        repeat (hold_off_cycles) @(negedge clk);
        hold_off_cycles = 0;
      end
      out_ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one byte; returns right after the edge that took it, with the
  // model's word for that byte. Each cycle idles with source_gap_pct odds.
  task automatic offer_byte(input logic [7:0] b, input logic lst,
                            output bit has_word, output ips_pkg::out_word_t word);
    @(negedge clk);
    while ($urandom_range(99) < source_gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.patch_byte = b;
    in_data.last = lst;
    do @(posedge clk); while (!in_ready);
    has_word = decode_patch_byte(b, lst, word);
  endtask

  // Send the buffered patch, last flag on its final byte.
  task automatic send_patch();
    bit                 has;
    ips_pkg::out_word_t w;
    foreach (patch_bytes[i]) begin
      offer_byte(patch_bytes[i], i == patch_bytes.size() - 1, has, w);
      if (has) predicted_words.push_back(w);
    end
  endtask

  // Stop offering and wait until every owed word is out, then let bytes that
  // made no word clear the parser.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (predicted_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle (pready is always high).
  task automatic write_rom_length(input logic [31:0] v);
    wait_for_results();
    cfg_paddr   = {ips_pkg::REG_ROM_LENGTH, 2'b00};
    cfg_pwdata  = v;
    cfg_pwrite  = 1'b1;
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    rom_length_cfg = v[24:0];
  endtask

  function automatic void append_be(input logic [23:0] v, input int unsigned n);
    for (int i = int'(n) - 1; i >= 0; i--) patch_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void append_header();
    for (int i = 0; i < 5; i++) patch_bytes.push_back(header_char(i));
  endfunction

  // Record offset for a record of len bytes, biased to the ROM end.
  function automatic logic [23:0] pick_offset(input int unsigned len);
    int unsigned lim;
    int unsigned r;
    int unsigned off;
    lim = rom_bound();
    r = $urandom_range(99);
    if (lim < len) off = $urandom_range(255);
    else if (r < 25) off = lim - len;                 // ends right at the ROM end
    else if (r < 35) off = lim - len + 1;             // one byte past it
    else if (r < 45) off = $urandom_range(32'hFF_FFFF);
    else off = $urandom_range(lim - len);
    return (off > 32'hFF_FFFF) ? 24'hFF_FFFF : off[23:0];
  endfunction

  // rom_length settings walked through during the run.
  function automatic logic [31:0] rom_setting(input int unsigned k);
    case (k % 8)
      0: return 32'(ips_pkg::ROM_MAX);
      1: return 32'd0;
      2: return 32'd1;
      3: return 32'h1FF_FFFF;                // above the max, clamps
      4: return 32'h100;
      5: return $urandom_range(32'h1_FFFF);
      6: return $urandom_range(32'h1FF_FFFF);
      default: return 32'(ips_pkg::ROM_MAX) - 1;
    endcase
  endfunction

  // Mostly well-formed patches with random records; some noise, some
  // truncated buffers and some with a damaged header.
  task automatic send_random_patch();
    int unsigned nrec;
    int unsigned roll;
    int unsigned len;
    patch_bytes.delete();
    if ($urandom_range(99) < 5) begin
      repeat ($urandom_range(1, 10)) patch_bytes.push_back(8'($urandom));
    end else begin
      append_header();
      nrec = $urandom_range(0, 5);
      for (int r = 0; r < nrec; r++) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          // payload record, mostly short
          len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
          append_be(pick_offset(len), 3);
          append_be(24'(len), 2);
          repeat (len) patch_bytes.push_back(8'($urandom));
        end else if (roll < 85) begin
          // RLE record, zero run count now and then
          len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 65535);
          append_be(pick_offset(len), 3);
          append_be(24'd0, 2);
          append_be(24'(len), 2);
          patch_bytes.push_back(8'($urandom));
        end else begin
          // big size header with no payload behind it: either out of
          // bounds, or the rest of the buffer becomes payload
          len = $urandom_range(1, 65535);
          append_be(pick_offset(len), 3);
          append_be(24'(len), 2);
          break;
        end
      end
      if ($urandom_range(99) < 80) begin
        append_be(ips_pkg::EOF_MARK, 3);
        repeat ($urandom_range(0, 2)) patch_bytes.push_back(8'($urandom));
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
        len = $urandom_range(1, patch_bytes.size());
        while (patch_bytes.size() > len) void'(patch_bytes.pop_back());
      end else if (roll < 15) begin
        patch_bytes[$urandom_range(4)] = 8'($urandom);
      end
    end
    send_patch();
  endtask

  // One long payload record while the receiver holds off, so the output
  // buffer fills and in_ready has to drop.
  task automatic send_backlog_patch();
    patch_bytes.delete();
    append_header();
    append_be(24'h10, 3);
    append_be(24'(BACKLOG_LEN), 2);
    repeat (BACKLOG_LEN) patch_bytes.push_back(8'($urandom));
    append_be(ips_pkg::EOF_MARK, 3);
    hold_off_cycles = BACKLOG_HOLD;
    send_patch();
  endtask

  task automatic add_row(input logic [7:0] b, input logic lst, input bit typed,
                         input bit has, input ips_pkg::out_word_t w);
    directed_rows.push_back('{b, lst, typed, has, w});
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    int unsigned        goal;
    int unsigned        next_switch;
    int unsigned        setting_idx;
    bit                 has;
    ips_pkg::out_word_t w;

    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rom_length_cfg = ips_pkg::ROM_MAX;
    restart_patch();
    setting_idx = 1;

    // Directed table.
    // Bad header on the first byte; the closing byte is then dropped.
    add_row(8'h58, 1'b0, 1'b1, 1'b1,
            '{ips_pkg::KIND_BADHDR, 24'h0, 8'h0, 16'h0, 25'h0});
    add_row(8'hFF, 1'b1, 1'b1, 1'b0, '0);
    // Header alone, then end of buffer: truncated.
    for (int i = 0; i < 4; i++) add_row(header_char(i), 1'b0, 1'b1, 1'b0, '0);
    add_row(header_char(4), 1'b1, 1'b1, 1'b1,
            '{ips_pkg::KIND_TRUNC, 24'h0, 8'h0, 16'h0, 25'h0});
    // Full patch: one-byte write at the top address ending exactly at the
    // ROM end, a zero-length fill at 0, then EOF.
    for (int i = 0; i < 5; i++) add_row(header_char(i), 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h01, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'hFF, 1'b0, 1'b1, 1'b1,
            '{ips_pkg::KIND_WRITE, 24'hFF_FFFF, 8'hFF, 16'h0, 25'h0});
    repeat (7) add_row(8'h00, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h7E, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h45, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h4F, 1'b0, 1'b0, 1'b0, '0);
    add_row(8'h46, 1'b1, 1'b1, 1'b1,
            '{ips_pkg::KIND_DONE, 24'h0, 8'h0, 16'h0, ips_pkg::ROM_MAX});

    // Synchronous reset, released on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      offer_byte(directed_rows[i].patch_byte, directed_rows[i].last, has, w);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has_word) predicted_words.push_back(directed_rows[i].word);
      end else if (has) begin
        predicted_words.push_back(w);
      end
    end

    // Three idling phases: slow receiver, slow sender, then full rate.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin source_gap_pct = 33; sink_stall_pct = 88; end
        1: begin source_gap_pct = 88; sink_stall_pct = 33; end
        default: begin source_gap_pct = 0; sink_stall_pct = 0; end
      endcase
      write_rom_length(32'(ips_pkg::ROM_MAX));
      send_backlog_patch();
      goal = live_bytes + LIVE_PER_PHASE;
      next_switch = live_bytes + 40;
      while (live_bytes < goal) begin
        // rom_length changes only at patch boundaries with nothing in flight
        if (live_bytes >= next_switch) begin
          write_rom_length(rom_setting(setting_idx));
          setting_idx++;
          next_switch = live_bytes + 40;
        end
        send_random_patch();
      end
    end

    wait_for_results();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS ips_patch_stream_parser_unit");
    end else begin
      $display("FAIL ips_patch_stream_parser_unit");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("FAIL ips_patch_stream_parser_unit");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/ips_pkg.sv
hdl/ips_cfg.sv
hdl/ips_parse.sv
hdl/ips_obuf.sv
hdl/ips_patch_stream_parser_unit.sv
tb/tb.sv
